### hdl/nsr_pkg.sv
// nsr_pkg: shared types and constants for the newton square root block
// no dependencies; imported by the register port, divider and top level
`timescale 1ns / 1ps

package nsr_pkg;

	// apb register map
	localparam int unsigned APB_ADDR_W = 3;
	localparam int unsigned APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-3:0] REG_TOLERANCE = 1'b0;
	localparam logic [31:0] TOLERANCE_RESET = 32'd1;

	// fixed port widths
	localparam int unsigned RADICAND_W = 32;
	localparam int unsigned ROOT_W = 32;
	localparam int unsigned TOLERANCE_W = 32;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_DIV   = 5'b00010,
		ST_DIFF  = 5'b00100,
		ST_CHECK = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	// handshake between sequencer and divider
	typedef struct packed {
		logic start;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic busy;
	} div_rsp_t;

endpackage

### hdl/nsr_apb_regs.sv
// nsr_apb_regs: apb register port holding the convergence tolerance
// depends on nsr_pkg
`timescale 1ns / 1ps

module nsr_apb_regs import nsr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [APB_ADDR_W-1:0]  paddr,
	input  logic [APB_DATA_W-1:0]  pwdata,
	output logic [APB_DATA_W-1:0]  prdata,
	output logic                   pready,
	output logic [TOLERANCE_W-1:0] tolerance
);

	logic [TOLERANCE_W-1:0] tolerance_q;
	logic                   hit;

	// word address decode, byte lanes ignored
	assign hit    = (paddr[APB_ADDR_W-1:2] == REG_TOLERANCE);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q <= TOLERANCE_RESET;
		end else if (psel && penable && pwrite && pready && hit) begin
			tolerance_q <= pwdata;
		end
	end

	assign prdata    = hit ? tolerance_q : '0;
	assign tolerance = tolerance_q;

endmodule

### hdl/nsr_div.sv
// nsr_div: restoring fixed-point divider, one quotient bit per cycle
// computes floor(a * 2^frac / g) saturated to all ones; depends on nsr_pkg
`timescale 1ns / 1ps

module nsr_div import nsr_pkg::*; #(
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned FRAC_BITS  = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  div_req_t              req,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output div_rsp_t              rsp,
	output logic [DATA_WIDTH-1:0] quotient
);

	localparam int unsigned SW = DATA_WIDTH + FRAC_BITS;
	localparam int unsigned CW = $clog2(SW + 1);

	logic [SW-1:0]         shift_q;
	logic [DATA_WIDTH-1:0] rem_q;
	logic [DATA_WIDTH-1:0] quo_q;
	logic [DATA_WIDTH-1:0] g_q;
	logic                  sat_q;
	logic [CW-1:0]         cnt_q;
	logic                  busy_q;
	logic                  done_q;

	logic [DATA_WIDTH:0]   rem_sh;
	logic [DATA_WIDTH:0]   rem_sub;
	logic                  fits;
	logic [DATA_WIDTH-1:0] quo_next;
	logic [DATA_WIDTH-1:0] rem_next;

	always_comb begin
		rem_sh   = {rem_q, shift_q[SW-1]};
		rem_sub  = rem_sh - {1'b0, g_q};
		fits     = (rem_sh >= {1'b0, g_q});
		quo_next = {quo_q[DATA_WIDTH-2:0], fits};
		rem_next = fits ? rem_sub[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		if (req.start) begin
			shift_q <= {dividend, {FRAC_BITS{1'b0}}};
			g_q     <= divisor;
			rem_q   <= '0;
			quo_q   <= '0;
			sat_q   <= 1'b0;
		end else if (busy_q) begin
			shift_q <= {shift_q[SW-2:0], 1'b0};
			rem_q   <= rem_next;
			quo_q   <= quo_next;
			// a one about to leave the top means the quotient overflows
			if (quo_q[DATA_WIDTH-1]) begin
				sat_q <= 1'b1;
			end
		end
	end

	assign quotient = sat_q ? '1 : quo_q;
	assign rsp.done = done_q;
	assign rsp.busy = busy_q;

endmodule

### hdl/newton_square_root.sv
// newton_square_root: top level, sequencer around the shared divider
// depends on nsr_pkg, nsr_apb_regs and nsr_div
`timescale 1ns / 1ps
//
// usage
//   s_* channel: one radicand item per handshake, s_tdata[31:0] = radicand
//   (unsigned, FRAC_BITS fraction bits). m_* channel: one result item per
//   radicand, m_tdata[31:0] = root, m_tuser[0] = limit_hit.
//   apb port: tolerance register at byte address 0, write only while idle.
// sequence
//   each newton step runs one division on the shared divider, then the sum,
//   difference and test; an item takes at most MAX_ITER steps.
//   s_tready is high only while the sequencer is idle; one item at a time.
// reset
//   arst_n clears the sequencer, divider and output valid; tolerance -> 1.
// stall
//   a finished result waits in the output register; the next item can be
//   taken meanwhile, but its own result waits until m_tready frees the slot.

module newton_square_root import nsr_pkg::*; #(
	parameter int unsigned FRAC_BITS  = 16,
	parameter int unsigned DATA_WIDTH = 32,
	parameter int unsigned MAX_ITER   = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// apb configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	// input items
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [RADICAND_W-1:0] s_tdata,   // [31:0] radicand
	// result items
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [ROOT_W-1:0]     m_tdata,   // [31:0] root
	output logic                  m_tuser    // [0] limit_hit
);

	localparam int unsigned DW = DATA_WIDTH;
	localparam int unsigned XW = (DW > 32) ? DW : 32;
	localparam int unsigned NW = $clog2(MAX_ITER + 1);
	localparam logic [DW-1:0] FIX_ONE = DW'(1) << FRAC_BITS;

	state_t state_q;

	logic [TOLERANCE_W-1:0] tolerance;
	logic [DW-1:0]          a_q;
	logic [DW-1:0]          prev_q;
	logic [DW-1:0]          next_q;
	logic [DW-1:0]          diff_q;
	logic [NW-1:0]          steps_q;
	logic                   flag_q;
	logic                   start_q;

	logic                   m_valid_q;
	logic [ROOT_W-1:0]      m_root_q;
	logic                   m_flag_q;

	div_req_t               div_req;
	div_rsp_t               div_rsp;
	logic [DW-1:0]          quo;

	logic [XW-1:0]          rad_x;
	logic [XW-1:0]          root_x;
	logic [XW-1:0]          diff_x;
	logic [XW-1:0]          tol_x;
	logic [DW:0]            sum;
	logic                   in_acc;
	logic                   out_free;

	nsr_apb_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.tolerance (tolerance)
	);

	assign div_req.start = start_q;

	nsr_div #(
		.DATA_WIDTH (DW),
		.FRAC_BITS  (FRAC_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (a_q),
		.divisor  (prev_q),
		.rsp      (div_rsp),
		.quotient (quo)
	);

	always_comb begin
		rad_x  = XW'(s_tdata);
		root_x = XW'(next_q);
		diff_x = XW'(diff_q);
		tol_x  = XW'(tolerance);
		sum    = {1'b0, prev_q} + {1'b0, quo};
	end

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			start_q   <= 1'b0;
			steps_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (m_valid_q && m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						steps_q <= NW'(1);
						// a zero starting guess ends at once with root zero
						if (FIX_ONE == '0) begin
							state_q <= ST_DONE;
						end else begin
							start_q <= 1'b1;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					state_q <= ST_CHECK;
				end
				ST_CHECK: begin
					if (diff_x < tol_x || next_q == '0 || steps_q >= NW'(MAX_ITER)) begin
						state_q <= ST_DONE;
					end else begin
						steps_q <= steps_q + NW'(1);
						start_q <= 1'b1;
						state_q <= ST_DIV;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						m_valid_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					a_q    <= rad_x[DW-1:0];
					prev_q <= FIX_ONE;
					next_q <= '0;
					flag_q <= 1'b0;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					next_q <= sum[DW:1];
				end
			end
			ST_DIFF: begin
				diff_q <= (next_q >= prev_q) ? (next_q - prev_q) : (prev_q - next_q);
			end
			ST_CHECK: begin
				if (diff_x < tol_x || next_q == '0) begin
					flag_q <= 1'b0;
				end else if (steps_q >= NW'(MAX_ITER)) begin
					flag_q <= 1'b1;
				end else begin
					prev_q <= next_q;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_root_q <= root_x[ROOT_W-1:0];
					m_flag_q <= flag_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_root_q;
	assign m_tuser  = m_flag_q;

endmodule

### tb/tb.sv
// tb: self-checking bench for newton_square_root, radicands in, roots out
// depends on nsr_pkg and the newton_square_root top level only
`timescale 1ns / 1ps

module tb;
	import nsr_pkg::*;

	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned DATA_WIDTH = 32;
	localparam int unsigned MAX_ITER   = 64;

	localparam logic [63:0] DMASK   = (64'd1 << DATA_WIDTH) - 64'd1;
	localparam logic [63:0] FIX_ONE = (64'd1 << FRAC_BITS) & DMASK;

	localparam logic [APB_ADDR_W-1:0] TOLERANCE_ADDR = {REG_TOLERANCE, 2'b00};

	localparam int WATCHDOG_LIMIT  = 20000;
	localparam int HOLD_OFF_CYCLES = 4000;
	localparam int END_SETTLE      = 2 * (DATA_WIDTH + FRAC_BITS + 4);
	localparam int RANDOM_PHASES   = 12;
	localparam int PHASE_ITEMS     = 60;

	typedef struct {
		logic [RADICAND_W-1:0] radicand;
		logic [ROOT_W-1:0]     root;
		logic                  limit_hit;
	} root_result_t;

	class sqrt_scoreboard;
		logic [TOLERANCE_W-1:0] tolerance;
		root_result_t expected_roots[$];
		int failures;
		int roots_checked;
		int limit_hits;

		function new();
			tolerance = TOLERANCE_RESET;
			failures = 0;
			roots_checked = 0;
			limit_hits = 0;
		endfunction

		function void set_tolerance(logic [TOLERANCE_W-1:0] value);
			tolerance = value;
		endfunction

		function int pending();
			return expected_roots.size();
		endfunction

		// one heron step from a nonzero guess, quotient saturated to the data width
		function logic [63:0] heron_step(logic [63:0] a, logic [63:0] g);
			logic [63:0] q;
			q = (a << FRAC_BITS) / g;
			if (q > DMASK)
				q = DMASK;
			return ((g + q) >> 1) & DMASK;
		endfunction

		function void note_radicand(logic [RADICAND_W-1:0] radicand);
			logic [63:0] a;
			logic [63:0] prev;
			logic [63:0] guess;
			logic [63:0] diff;
			int steps;
			root_result_t res;
			a = {32'd0, radicand} & DMASK;
			prev = FIX_ONE;
			guess = heron_step(a, prev);
			steps = 1;
			res.radicand = radicand;
			res.limit_hit = 1'b0;
			forever begin
				diff = (guess >= prev) ? guess - prev : prev - guess;
				if (diff < {32'd0, tolerance})
					break;
				// a guess truncated to zero counts as converged
				if (guess == 0)
					break;
				if (steps >= MAX_ITER) begin
					res.limit_hit = 1'b1;
					break;
				end
				prev = guess;
				guess = heron_step(a, prev);
				steps++;
			end
			res.root = guess[ROOT_W-1:0];
			expected_roots.push_back(res);
		endfunction

		function void check_root(logic [ROOT_W-1:0] root, logic limit_hit);
			root_result_t exp_res;
			if (expected_roots.size() == 0) begin
				$display("%0t: unexpected result item: root %h limit_hit %b",
					$time, root, limit_hit);
				failures++;
				return;
			end
			exp_res = expected_roots.pop_front();
			roots_checked++;
			if (exp_res.limit_hit)
				limit_hits++;
			if (root !== exp_res.root) begin
				$display("%0t: root mismatch for radicand %h: expected %h, actual %h",
					$time, exp_res.radicand, exp_res.root, root);
				failures++;
			end
			if (limit_hit !== exp_res.limit_hit) begin
				$display("%0t: limit_hit mismatch for radicand %h: expected %b, actual %b",
					$time, exp_res.radicand, exp_res.limit_hit, limit_hit);
				failures++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [RADICAND_W-1:0] s_tdata;   // [31:0] radicand
	logic                  m_tvalid;
	logic                  m_tready;
	logic [ROOT_W-1:0]     m_tdata;   // [31:0] root
	logic                  m_tuser;   // [0] limit_hit

	sqrt_scoreboard sb = new();

	int send_idle_pct = 34;
	int recv_idle_pct = 63;
	bit hold_off_req = 1'b0;

	// corners of the radicand range, zero and exact powers of two among them
	logic [31:0] corner_radicands [16] = '{
		32'h0000_0000, 32'h0000_0001, 32'h0000_0002, 32'h0000_8000,
		32'h0000_FFFF, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000,
		32'h0009_0000, 32'h0100_0000, 32'h5555_5555, 32'hAAAA_AAAA,
		32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_0000, 32'hFFFF_FFFF
	};

	always #6 clk = ~clk;

	newton_square_root #(
		.FRAC_BITS  (FRAC_BITS),
		.DATA_WIDTH (DATA_WIDTH),
		.MAX_ITER   (MAX_ITER)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	task automatic write_tolerance(input logic [TOLERANCE_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= TOLERANCE_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_tolerance(value);
	endtask

	task automatic offer_radicand(input logic [RADICAND_W-1:0] radicand);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= radicand;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_radicand(radicand);
	endtask

	// sender stops and waits for every outstanding root
	task automatic wait_for_roots();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_radicand();
		logic [31:0] k;
		case ($urandom_range(5))
			0: return $urandom_range(32'h0000_FFFF);
			1: begin
				// near a perfect square, where truncation is most delicate
				k = $urandom_range(255);
				return ((k * k) << 16) + $urandom_range(3) - 32'd1;
			end
			2: return 32'hFFFF_FFFF - $urandom_range(255);
			3: return $urandom >> $urandom_range(31);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_tolerance(int phase);
		logic [31:0] t;
		case (phase % 4)
			0: t = 32'd1;
			1: t = $urandom_range(2, 64);
			2: t = $urandom_range(65, 32'h0001_0000);
			default: t = (phase == 3) ? 32'hFFFF_FFFF : $urandom;
		endcase
		return (t == 0) ? 32'd1 : t;
	endfunction

	initial begin : result_sink
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready)
				sb.check_root(m_tdata, m_tuser);
			if (hold_off_req) begin
				// long stall so the block fills and backs up its input
				m_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES)
					@(posedge clk);
				hold_off_req = 1'b0;
			end
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	initial begin : stimulus
		int items_sent;
		int settings_used;
		items_sent = 0;
		settings_used = 0;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners at tolerance one, the smallest that can converge
		write_tolerance(32'd1);
		settings_used++;
		foreach (corner_radicands[i]) begin
			offer_radicand(corner_radicands[i]);
			items_sent++;
		end
		wait_for_roots();

		// zero tolerance never converges, so items run to the step limit unless the guess reaches zero
		write_tolerance(32'd0);
		settings_used++;
		offer_radicand(32'h0001_0000);
		offer_radicand(32'h0000_0000);
		offer_radicand(32'hFFFF_FFFF);
		items_sent += 3;
		wait_for_roots();

		// largest tolerance stops after the first step
		write_tolerance(32'hFFFF_FFFF);
		settings_used++;
		offer_radicand(32'h0000_0000);
		offer_radicand(32'h0004_0000);
		offer_radicand(32'hFFFF_FFFF);
		items_sent += 3;
		wait_for_roots();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			if (p < 4) begin
				send_idle_pct = 34;
				recv_idle_pct = 63;
			end else if (p < 8) begin
				send_idle_pct = 63;
				recv_idle_pct = 34;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_tolerance(pick_tolerance(p));
			settings_used++;
			if (p == 8)
				hold_off_req = 1'b1;
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				offer_radicand(pick_radicand());
				items_sent++;
			end
			wait_for_roots();
		end

		repeat (END_SETTLE)
			@(posedge clk);

		$display("covered %0d radicands under %0d tolerance settings, stalls on both sides",
			items_sent, settings_used);
		$display("%0d roots checked, %0d of them ended at the step limit",
			sb.roots_checked, sb.limit_hits);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
